FILE: rtl/risc_instruction_execute_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RISC instruction execute block
// Implication checks on the block's own control logic.
// ----------------------------------------------------------------------------
`ifndef RISC_INSTRUCTION_EXECUTE_ASSERT_SVH
`define RISC_INSTRUCTION_EXECUTE_ASSERT_SVH

// same-cycle implication
`define RIE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("execute block check failed");

// next-cycle implication
`define RIE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("execute block check failed");

`endif

FILE: rtl/rie_pkg.sv
// ----------------------------------------------------------------------------
// rie_pkg
// Constants, codes, types and helpers of the RISC instruction execute block.
// ----------------------------------------------------------------------------
package rie_pkg;

  localparam int XLEN         = 32;
  localparam int REG_COUNT    = 16;
  localparam int REG_AW       = 4;
  localparam int IMM_BITS     = 12;
  localparam int PC_BITS      = 12;
  localparam int DATA_AW      = 12;
  localparam int DATA_WORDS   = 1 << DATA_AW;
  localparam int IO_REG_COUNT = 32;
  localparam int IO_AW        = $clog2(IO_REG_COUNT);
  localparam int IO_IDX_BITS  = 5;
  localparam int OP_BITS      = 5;
  localparam int STATUS_BITS  = 2;
  localparam int RETI_VEC_IDX = 7;
  localparam int IMM1_REG     = 1;
  localparam int IMM2_REG     = 2;

  // opcodes
  typedef enum logic [OP_BITS-1:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MAD  = 5'd2,
    OP_AND  = 5'd3,
    OP_OR   = 5'd4,
    OP_XOR  = 5'd5,
    OP_SLL  = 5'd6,
    OP_SRA  = 5'd7,
    OP_SRL  = 5'd8,
    OP_BEQ  = 5'd9,
    OP_BNE  = 5'd10,
    OP_BLT  = 5'd11,
    OP_BGT  = 5'd12,
    OP_BLE  = 5'd13,
    OP_BGE  = 5'd14,
    OP_JAL  = 5'd15,
    OP_LD   = 5'd16,
    OP_ST   = 5'd17,
    OP_RETI = 5'd18,
    OP_IN   = 5'd19,
    OP_OUT  = 5'd20,
    OP_HALT = 5'd21
  } op_e;

  // result status
  typedef enum logic [STATUS_BITS-1:0] {
    ST_RUN     = 2'd0,
    ST_HALT    = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_e;

  // decoded instruction as it moves down the pipe
  typedef struct packed {
    logic [OP_BITS-1:0]  op;
    logic [REG_AW-1:0]   rd;
    logic [REG_AW-1:0]   rs;
    logic [REG_AW-1:0]   rt;
    logic [REG_AW-1:0]   rm;
    logic [IMM_BITS-1:0] imm1;
    logic [IMM_BITS-1:0] imm2;
  } instr_t;

  function automatic logic [XLEN-1:0] sext_imm(input logic [IMM_BITS-1:0] imm);
    return {{(XLEN-IMM_BITS){imm[IMM_BITS-1]}}, imm};
  endfunction

  // Register read cleanup: never-written entries read zero, a write from the
  // previous edge is forwarded, registers 1 and 2 always hold the immediates.
  function automatic logic [XLEN-1:0] fix_operand(
    input logic [XLEN-1:0]      raw,
    input logic [REG_AW-1:0]    idx,
    input logic [REG_COUNT-1:0] vld,
    input logic                 fwd_en,
    input logic [REG_AW-1:0]    fwd_addr,
    input logic [XLEN-1:0]      fwd_data,
    input logic [IMM_BITS-1:0]  imm1,
    input logic [IMM_BITS-1:0]  imm2
  );
    logic [XLEN-1:0] val;
    val = vld[idx] ? raw : '0;
    if (fwd_en && (fwd_addr == idx)) val = fwd_data;
    if (idx == REG_AW'(IMM1_REG)) val = sext_imm(imm1);
    if (idx == REG_AW'(IMM2_REG)) val = sext_imm(imm2);
    return val;
  endfunction

endpackage

FILE: rtl/rie_if.sv
// ----------------------------------------------------------------------------
// rie_in_if / rie_out_if
// Valid/ready channels for instruction words and result words.
// ----------------------------------------------------------------------------
interface rie_in_if;
  logic                valid;
  logic                ready;
  logic [4:0]          opcode;
  logic [3:0]          dest_reg;
  logic [3:0]          src_a_reg;
  logic [3:0]          src_b_reg;
  logic [3:0]          src_c_reg;
  logic signed [11:0]  imm_one;
  logic signed [11:0]  imm_two;

  modport source (output valid, opcode, dest_reg, src_a_reg, src_b_reg, src_c_reg,
                  imm_one, imm_two, input ready);
  modport sink   (input valid, opcode, dest_reg, src_a_reg, src_b_reg, src_c_reg,
                  imm_one, imm_two, output ready);
endinterface

interface rie_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [11:0]        next_pc;
  logic               io_write_valid;
  logic [4:0]         io_write_index;
  logic signed [31:0] io_write_data;

  modport source (output valid, status, next_pc, io_write_valid, io_write_index,
                  io_write_data, input ready);
  modport sink   (input valid, status, next_pc, io_write_valid, io_write_index,
                  io_write_data, output ready);
endinterface

FILE: rtl/rie_ram.sv
// ----------------------------------------------------------------------------
// rie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port, read port holds its data while idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/risc_instruction_execute.sv
// ----------------------------------------------------------------------------
// risc_instruction_execute
// Execute stage of a small 32-bit register machine, one decoded instruction
// per input word, one result word (status, next pc, IO write) per instruction.
// ----------------------------------------------------------------------------
// A new instruction word is accepted only once the previous one has left
// the second register read round and, if in execute, moves its result on;
// the two read rounds cause the wait. Results pass the s1 and s2 registers
// to the output register. The register file lives in two copies of a 16 x
// 32 RAM with one read port each: the accept edge reads rs and rt, the
// following edge reads rm and rd with the data memory word at rs+rt, and
// execute writes back on the edge on which its result enters the output
// register. A write from the previous instruction is forwarded into the
// rs/rt operands. After reset the 4096-word data memory is cleared one word
// per cycle, so no instruction is accepted until the clear is done. The
// output register lets the next instruction enter while a result waits.
// ----------------------------------------------------------------------------
`include "risc_instruction_execute_assert.svh"

module risc_instruction_execute (
  input  logic      clk_i,
  input  logic      rst_ni,
  rie_in_if.sink    in_i,
  rie_out_if.source out_o
);

  // data memory clear after reset
  logic                        clearing_q;
  logic [rie_pkg::DATA_AW-1:0] clr_addr_q;

  // pipeline control
  logic in_fire;
  logic in_ready;
  logic s1_valid_q;
  logic s2_valid_q;
  logic s2_fire;

  rie_pkg::instr_t s1_q;
  rie_pkg::instr_t s2_q;
  rie_pkg::instr_t in_instr;

  // operands carried from the first read round
  logic [rie_pkg::XLEN-1:0] a_s1, b_s1, sum_s1, prod_s1;
  logic [rie_pkg::XLEN-1:0] a_q, b_q, sum_q, prod_q;

  // last register write, forwarded for one cycle
  logic                       wb_en_q;
  logic [rie_pkg::REG_AW-1:0] wb_addr_q;
  logic [rie_pkg::XLEN-1:0]   wb_data_q;

  // architectural state outside the RAMs
  logic [rie_pkg::REG_COUNT-1:0] rf_valid_q;
  logic [rie_pkg::PC_BITS-1:0]   pc_q;
  logic [rie_pkg::XLEN-1:0]      io_q [rie_pkg::IO_REG_COUNT];

  // RAM ports
  logic                       rf_re;
  logic [rie_pkg::REG_AW-1:0] rf_raddr0, rf_raddr1;
  logic [rie_pkg::XLEN-1:0]   rf_rdata0, rf_rdata1;
  logic                       rf_we;
  logic [rie_pkg::XLEN-1:0]   rf_wdata;
  logic                        dm_we;
  logic [rie_pkg::DATA_AW-1:0] dm_waddr;
  logic [rie_pkg::XLEN-1:0]    dm_wdata;
  logic [rie_pkg::XLEN-1:0]    dm_rdata;

  // execute results
  logic [rie_pkg::XLEN-1:0]        c_s2, d_s2, res;
  logic                            res_we;
  logic                            jump;
  logic [rie_pkg::PC_BITS-1:0]     target, pc_inc, pc_next;
  logic [rie_pkg::STATUS_BITS-1:0] status;
  logic                            st_we;
  logic                            io_hit;
  logic                            io_we;
  logic [rie_pkg::IO_AW-1:0]       io_idx;

  // output register
  logic                            out_valid_q;
  logic [rie_pkg::STATUS_BITS-1:0] out_status_q;
  logic [rie_pkg::PC_BITS-1:0]     out_pc_q;
  logic                            out_io_v_q;
  logic [rie_pkg::IO_IDX_BITS-1:0] out_io_i_q;
  logic [rie_pkg::XLEN-1:0]        out_io_d_q;

  // handshakes
  assign s2_fire  = s2_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !clearing_q && !s1_valid_q && (!s2_valid_q || s2_fire);
  assign in_fire  = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  always_comb begin
    in_instr.op   = in_i.opcode;
    in_instr.rd   = in_i.dest_reg;
    in_instr.rs   = in_i.src_a_reg;
    in_instr.rt   = in_i.src_b_reg;
    in_instr.rm   = in_i.src_c_reg;
    in_instr.imm1 = in_i.imm_one;
    in_instr.imm2 = in_i.imm_two;
  end

  // register file reads: rs/rt on accept, rm/rd in the cycle after
  assign rf_re     = in_fire || s1_valid_q;
  assign rf_raddr0 = s1_valid_q ? s1_q.rm : in_i.src_a_reg;
  assign rf_raddr1 = s1_valid_q ? s1_q.rd : in_i.src_b_reg;

  rie_ram #(.WIDTH(rie_pkg::XLEN), .DEPTH(rie_pkg::REG_COUNT)) u_rf_bank0 (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_q.rd),
    .wdata_i (rf_wdata),
    .re_i    (rf_re),
    .raddr_i (rf_raddr0),
    .rdata_o (rf_rdata0)
  );

  rie_ram #(.WIDTH(rie_pkg::XLEN), .DEPTH(rie_pkg::REG_COUNT)) u_rf_bank1 (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_q.rd),
    .wdata_i (rf_wdata),
    .re_i    (rf_re),
    .raddr_i (rf_raddr1),
    .rdata_o (rf_rdata1)
  );

  // first round operands, address and product
  always_comb begin
    a_s1 = rie_pkg::fix_operand(rf_rdata0, s1_q.rs, rf_valid_q, wb_en_q, wb_addr_q,
                                wb_data_q, s1_q.imm1, s1_q.imm2);
    b_s1 = rie_pkg::fix_operand(rf_rdata1, s1_q.rt, rf_valid_q, wb_en_q, wb_addr_q,
                                wb_data_q, s1_q.imm1, s1_q.imm2);
    sum_s1  = a_s1 + b_s1;
    prod_s1 = a_s1 * b_s1;
  end

  // data memory: clear sweep, store write, load read in the second round
  always_comb begin
    if (clearing_q) begin
      dm_we    = 1'b1;
      dm_waddr = clr_addr_q;
      dm_wdata = '0;
    end else begin
      dm_we    = s2_fire && st_we;
      dm_waddr = sum_q[rie_pkg::DATA_AW-1:0];
      dm_wdata = c_s2 + d_s2;
    end
  end

  rie_ram #(.WIDTH(rie_pkg::XLEN), .DEPTH(rie_pkg::DATA_WORDS)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .re_i    (s1_valid_q),
    .raddr_i (sum_s1[rie_pkg::DATA_AW-1:0]),
    .rdata_o (dm_rdata)
  );

  // execute
  always_comb begin
    c_s2 = rie_pkg::fix_operand(rf_rdata0, s2_q.rm, rf_valid_q, 1'b0, '0, '0,
                                s2_q.imm1, s2_q.imm2);
    d_s2 = rie_pkg::fix_operand(rf_rdata1, s2_q.rd, rf_valid_q, 1'b0, '0, '0,
                                s2_q.imm1, s2_q.imm2);
    pc_inc = pc_q + 1'b1;
    io_idx = sum_q[rie_pkg::IO_AW-1:0];
    io_hit = (sum_q < rie_pkg::XLEN'(rie_pkg::IO_REG_COUNT));
    res    = '0;
    res_we = 1'b0;
    jump   = 1'b0;
    target = c_s2[rie_pkg::PC_BITS-1:0];
    status = rie_pkg::ST_RUN;
    st_we  = 1'b0;
    io_we  = 1'b0;
    unique case (s2_q.op)
      rie_pkg::OP_ADD: begin res = a_q + b_q + c_s2; res_we = 1'b1; end
      rie_pkg::OP_SUB: begin res = a_q - b_q - c_s2; res_we = 1'b1; end
      rie_pkg::OP_MAD: begin res = prod_q + c_s2; res_we = 1'b1; end
      rie_pkg::OP_AND: begin res = a_q & b_q & c_s2; res_we = 1'b1; end
      rie_pkg::OP_OR:  begin res = a_q | b_q | c_s2; res_we = 1'b1; end
      rie_pkg::OP_XOR: begin res = a_q ^ b_q ^ c_s2; res_we = 1'b1; end
      rie_pkg::OP_SLL: begin res = a_q << b_q[4:0]; res_we = 1'b1; end
      rie_pkg::OP_SRA: begin
        res    = rie_pkg::XLEN'($signed(a_q) >>> b_q[4:0]);
        res_we = 1'b1;
      end
      rie_pkg::OP_SRL: begin res = a_q >> b_q[4:0]; res_we = 1'b1; end
      rie_pkg::OP_BEQ: jump = (a_q == b_q);
      rie_pkg::OP_BNE: jump = (a_q != b_q);
      rie_pkg::OP_BLT: jump = ($signed(a_q) < $signed(b_q));
      rie_pkg::OP_BGT: jump = ($signed(a_q) > $signed(b_q));
      rie_pkg::OP_BLE: jump = ($signed(a_q) <= $signed(b_q));
      rie_pkg::OP_BGE: jump = ($signed(a_q) >= $signed(b_q));
      rie_pkg::OP_JAL: begin
        res    = rie_pkg::XLEN'(pc_inc);
        res_we = 1'b1;
        jump   = 1'b1;
      end
      rie_pkg::OP_LD: begin res = dm_rdata + c_s2; res_we = 1'b1; end
      rie_pkg::OP_ST: st_we = 1'b1;
      rie_pkg::OP_RETI: begin
        jump   = 1'b1;
        target = io_q[rie_pkg::RETI_VEC_IDX][rie_pkg::PC_BITS-1:0];
      end
      rie_pkg::OP_IN: begin
        res    = io_hit ? io_q[io_idx] : '0;
        res_we = 1'b1;
      end
      rie_pkg::OP_OUT:  io_we = io_hit;
      rie_pkg::OP_HALT: status = rie_pkg::ST_HALT;
      default:          status = rie_pkg::ST_ILLEGAL;
    endcase
    pc_next = jump ? target : pc_inc;
  end

  assign rf_we    = s2_fire && res_we;
  assign rf_wdata = res;

  // control registers and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      wb_en_q     <= 1'b0;
      rf_valid_q  <= '0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < rie_pkg::IO_REG_COUNT; i++) begin
        io_q[i] <= '0;
      end
    end else begin
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == rie_pkg::DATA_AW'(rie_pkg::DATA_WORDS - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      s1_valid_q <= in_fire;
      if (s1_valid_q) begin
        s2_valid_q <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
      wb_en_q <= rf_we;
      if (rf_we) begin
        rf_valid_q[s2_q.rd] <= 1'b1;
      end
      if (s2_fire) begin
        pc_q <= pc_next;
        if (io_we) begin
          io_q[io_idx] <= c_s2;
        end
      end
      if (s2_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_instr;
    end
    if (s1_valid_q) begin
      s2_q   <= s1_q;
      a_q    <= a_s1;
      b_q    <= b_s1;
      sum_q  <= sum_s1;
      prod_q <= prod_s1;
    end
    wb_addr_q <= s2_q.rd;
    wb_data_q <= res;
    if (s2_fire) begin
      out_status_q <= status;
      out_pc_q     <= pc_next;
      out_io_v_q   <= io_we;
      out_io_i_q   <= io_we ? sum_q[rie_pkg::IO_IDX_BITS-1:0] : '0;
      out_io_d_q   <= io_we ? c_s2 : '0;
    end
  end

  // result channel
  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.next_pc        = out_pc_q;
  assign out_o.io_write_valid = out_io_v_q;
  assign out_o.io_write_index = out_io_i_q;
  assign out_o.io_write_data  = out_io_d_q;

  // checks
  `RIE_ASSERT_IMP(a_s1_s2_excl, clk_i, rst_ni, s1_valid_q, !s2_valid_q)
  `RIE_ASSERT_NXT(a_accept_reads, clk_i, rst_ni, in_fire, s1_valid_q && !in_ready)
  `RIE_ASSERT_NXT(a_exec_to_out, clk_i, rst_ni, s2_fire, out_valid_q && !s2_valid_q)

endmodule
